>>> hw/rtl/mwe_pkg.sv
`default_nettype none

package mwe_pkg;

  // Width of one EEPROM word.
  localparam int unsigned DataBits = 16;

  // Bit counter width: holds up to DataBits + 1 (dummy bit plus word).
  localparam int unsigned CntBits = $clog2(DataBits + 2);

  // Request codes carried in the action field.
  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActRead  = 2'd1,
    ActWrite = 2'd2
  } mwe_action_e;

  // Register index of the configuration port.
  localparam logic RegLargePart = 1'b0;

  // Serial command patterns, first bit sent in bit 0.
  localparam logic [10:0] EwenSeq = 11'b000_0001_1001;
  localparam logic [10:0] EwdsSeq = 11'b000_0000_0001;
  localparam logic [2:0]  WriteOp = 3'b101;
  localparam logic [2:0]  ReadOp  = 3'b011;

  // One input item.
  typedef struct packed {
    logic [1:0]          action;
    logic [7:0]          address;
    logic [DataBits-1:0] write_data;
    logic                data_in;
  } mwe_req_t;

  // One result item.
  typedef struct packed {
    logic                chip_select;
    logic                serial_clock;
    logic                serial_out;
    logic                busy_res;
    logic                accepted;
    logic                read_valid;
    logic [DataBits-1:0] read_data;
    logic                write_done;
  } mwe_rsp_t;

  // Bit of a command pattern at a given slot; zero past its end.
  function automatic logic seq_bit(logic [10:0] seq, logic [CntBits-1:0] idx);
    logic res;
    res = 1'b0;
    if (idx < CntBits'(11)) begin
      res = seq[idx[3:0]];
    end
    return res;
  endfunction

  function automatic logic op_bit(logic [2:0] op, logic [CntBits-1:0] idx);
    logic res;
    res = 1'b0;
    if (idx < CntBits'(3)) begin
      res = op[idx[1:0]];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mwe_req_if.sv
`default_nettype none

interface mwe_req_if;
  import mwe_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [7:0]          address;
  logic [DataBits-1:0] write_data;
  logic                data_in;

  modport source (output valid, action, address, write_data, data_in, input ready);
  modport sink   (input valid, action, address, write_data, data_in, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mwe_rsp_if.sv
`default_nettype none

interface mwe_rsp_if;
  import mwe_pkg::*;

  logic                valid;
  logic                ready;
  logic                chip_select;
  logic                serial_clock;
  logic                serial_out;
  logic                busy_res;
  logic                accepted;
  logic                read_valid;
  logic [DataBits-1:0] read_data;
  logic                write_done;

  modport source (output valid, chip_select, serial_clock, serial_out, busy_res, accepted,
                  read_valid, read_data, write_done, input ready);
  modport sink   (input valid, chip_select, serial_clock, serial_out, busy_res, accepted,
                  read_valid, read_data, write_done, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mwe_cfg.sv
`default_nettype none

module mwe_cfg import mwe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        large_part_o
);

  logic large_part_q, large_part_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegLargePart);

  always_comb begin
    large_part_d = large_part_q;
    if (wr_en) begin
      large_part_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_part_q <= 1'b0;
    end else begin
      large_part_q <= large_part_d;
    end
  end

  // Only the lower word address holds a register; the rest reads as zero.
  assign prdata = (paddr[2] == RegLargePart) ? {31'd0, large_part_q} : 32'd0;

  assign large_part_o = large_part_q;

endmodule

`default_nettype wire

>>> hw/rtl/mwe_core.sv
`default_nettype none

module mwe_core import mwe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     large_part_i,
  input  logic     in_valid_i,
  input  mwe_req_t in_item_i,
  output logic     res_valid_o,
  output mwe_rsp_t res_o
);

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhEnPre   = 4'd1;
  localparam logic [3:0] PhEnBits  = 4'd2;
  localparam logic [3:0] PhEnRst   = 4'd3;
  localparam logic [3:0] PhCmdPre  = 4'd4;
  localparam logic [3:0] PhCmdBits = 4'd5;
  localparam logic [3:0] PhAddr    = 4'd6;
  localparam logic [3:0] PhRdData  = 4'd7;
  localparam logic [3:0] PhRdRst   = 4'd8;
  localparam logic [3:0] PhWrData  = 4'd9;
  localparam logic [3:0] PhWrDrop  = 4'd10;
  localparam logic [3:0] PhWrPoll  = 4'd11;
  localparam logic [3:0] PhWrRst   = 4'd12;
  localparam logic [3:0] PhDsPre   = 4'd13;
  localparam logic [3:0] PhDsBits  = 4'd14;
  localparam logic [3:0] PhDsRst   = 4'd15;

  // Input register.
  logic     s1_valid_q;
  mwe_req_t s1_item_q;

  // Sequencer state.
  logic [3:0]          phase_q, phase_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [DataBits-1:0] word_q, word_d;
  logic [7:0]          addr_q, addr_d;
  logic                is_wr_q, is_wr_d;
  logic [2:0]          pins_q, pins_d;

  // Shared half-slot stepper and reset stepper.
  logic               sk_high;
  logic [CntBits-1:0] cnt_inc;
  logic               sh_bit;
  logic [CntBits-1:0] sh_len;
  logic [2:0]         sh_pins;
  logic [CntBits-1:0] sh_cnt;
  logic               sh_last;
  logic [2:0]         rs_pins;
  logic               rs_done;
  logic [CntBits-1:0] rs_cnt;
  logic [2:0]         addr_msb;
  logic [CntBits-1:0] addr_len;
  logic               rd_valid, wr_done;

  assign sk_high  = pins_q[1];
  assign cnt_inc  = cnt_q + CntBits'(1);
  assign addr_msb = large_part_i ? 3'd7 : 3'd5;
  assign addr_len = large_part_i ? CntBits'(8) : CntBits'(6);

  // Bit and length for the phase that shifts out.
  always_comb begin
    sh_bit = 1'b0;
    sh_len = CntBits'(DataBits);
    case (phase_q)
      PhEnBits: begin
        sh_bit = seq_bit(EwenSeq, cnt_q);
        sh_len = large_part_i ? CntBits'(11) : CntBits'(9);
      end
      PhDsBits: begin
        sh_bit = seq_bit(EwdsSeq, cnt_q);
        sh_len = large_part_i ? CntBits'(11) : CntBits'(9);
      end
      PhCmdBits: begin
        sh_bit = op_bit(is_wr_q ? WriteOp : ReadOp, cnt_q);
        sh_len = CntBits'(3);
      end
      PhAddr: begin
        sh_bit = (cnt_q < addr_len) ? addr_q[addr_msb - cnt_q[2:0]] : 1'b0;
        sh_len = addr_len;
      end
      PhRdData: begin
        sh_bit = 1'b0;
        sh_len = CntBits'(DataBits + 1);
      end
      PhWrData: begin
        sh_bit = word_q[DataBits-1];
        sh_len = CntBits'(DataBits);
      end
      default: begin
        sh_bit = 1'b0;
        sh_len = CntBits'(DataBits);
      end
    endcase
  end

  // A high SK is followed by a low step that sets up the bit; a low SK by
  // the rising step that clocks it and counts it.
  assign sh_pins = sk_high ? {2'b10, sh_bit} : {2'b11, sh_bit};
  assign sh_cnt  = sk_high ? cnt_q : cnt_inc;
  assign sh_last = !sk_high && (cnt_inc >= sh_len);

  // Three-step reset: CS low, SK pulses on the middle step.
  assign rs_pins = {1'b0, cnt_q == CntBits'(1), 1'b0};
  assign rs_done = cnt_q >= CntBits'(2);
  assign rs_cnt  = rs_done ? '0 : cnt_inc;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    word_d   = word_q;
    addr_d   = addr_q;
    is_wr_d  = is_wr_q;
    pins_d   = pins_q;
    rd_valid = 1'b0;
    wr_done  = 1'b0;
    res_o    = '0;
    if (s1_valid_q) begin
      if (phase_q == PhIdle) begin
        if (s1_item_q.action == ActRead || s1_item_q.action == ActWrite) begin
          res_o.accepted = 1'b1;
          addr_d  = s1_item_q.address;
          is_wr_d = (s1_item_q.action == ActWrite);
          word_d  = (s1_item_q.action == ActWrite) ? s1_item_q.write_data : '0;
          cnt_d   = '0;
          phase_d = (s1_item_q.action == ActWrite) ? PhEnPre : PhCmdPre;
        end
      end else if (s1_item_q.action == ActTick) begin
        case (phase_q)
          PhEnPre, PhCmdPre, PhDsPre: begin
            pins_d  = 3'b110;
            cnt_d   = '0;
            phase_d = phase_q + 4'd1;
          end
          PhEnBits, PhDsBits, PhCmdBits: begin
            pins_d = sh_pins;
            cnt_d  = sh_cnt;
            if (sh_last) begin
              cnt_d = '0;
              if (phase_q == PhEnBits) begin
                phase_d = PhEnRst;
              end else if (phase_q == PhDsBits) begin
                phase_d = PhDsRst;
              end else begin
                phase_d = PhAddr;
              end
            end
          end
          PhAddr: begin
            pins_d = sh_pins;
            cnt_d  = sh_cnt;
            if (sh_last) begin
              cnt_d = '0;
              if (is_wr_q) begin
                phase_d = PhWrData;
              end else begin
                phase_d = PhRdData;
                word_d  = '0;
              end
            end
          end
          PhRdData: begin
            pins_d = sh_pins;
            cnt_d  = sh_cnt;
            if (sk_high) begin
              word_d = {word_q[DataBits-2:0], s1_item_q.data_in};
            end else if (sh_last) begin
              cnt_d   = '0;
              phase_d = PhRdRst;
            end
          end
          PhWrData: begin
            pins_d = sh_pins;
            cnt_d  = sh_cnt;
            if (!sk_high) begin
              word_d = {word_q[DataBits-2:0], 1'b0};
            end
            if (sh_last) begin
              cnt_d   = '0;
              phase_d = PhWrDrop;
            end
          end
          PhWrDrop: begin
            pins_d  = 3'b000;
            cnt_d   = '0;
            phase_d = PhWrPoll;
          end
          PhWrPoll: begin
            if (!cnt_q[0]) begin
              pins_d = 3'b100;
              cnt_d  = CntBits'(1);
            end else begin
              pins_d = 3'b110;
              cnt_d  = '0;
              if (s1_item_q.data_in) begin
                phase_d = PhWrRst;
              end
            end
          end
          PhEnRst, PhRdRst, PhWrRst, PhDsRst: begin
            pins_d = rs_pins;
            cnt_d  = rs_cnt;
            if (rs_done) begin
              case (phase_q)
                PhEnRst: phase_d = PhCmdPre;
                PhWrRst: phase_d = PhDsPre;
                PhRdRst: begin
                  phase_d  = PhIdle;
                  rd_valid = 1'b1;
                end
                default: begin
                  phase_d = PhIdle;
                  wr_done = 1'b1;
                end
              endcase
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
      res_o.chip_select  = pins_d[2];
      res_o.serial_clock = pins_d[1];
      res_o.serial_out   = pins_d[0];
      res_o.busy_res     = (phase_d != PhIdle);
      res_o.read_valid   = rd_valid;
      res_o.read_data    = rd_valid ? word_q : '0;
      res_o.write_done   = wr_done;
    end
  end

  assign res_valid_o = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= PhIdle;
      cnt_q      <= '0;
      word_q     <= '0;
      addr_q     <= '0;
      is_wr_q    <= 1'b0;
      pins_q     <= 3'b000;
    end else begin
      s1_valid_q <= in_valid_i;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      word_q     <= word_d;
      addr_q     <= addr_d;
      is_wr_q    <= is_wr_d;
      pins_q     <= pins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mwe_outq.sv
`default_nettype none

module mwe_outq import mwe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mwe_rsp_t   push_data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output mwe_rsp_t   data_o,
  output logic [1:0] count_o
);

  mwe_rsp_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

>>> hw/rtl/microwire_eeprom_master.sv
// Microwire master for 93C46/56/66 serial EEPROMs in 16-bit organization.
// A read or write request on the req channel loads a sequence; every tick
// item after that moves the CS, SK and DO pins by one half-clock step, and
// every item, request or tick, yields exactly one result on the rsp channel
// carrying the new pin levels and status. A read sends the start bit,
// opcode 10 and the address MSB first, clocks 17 bits and returns the last
// 16 as read_data with read_valid. A write sends EWEN, then 101, the address
// and the data word, drops CS for one step, polls the ready flag with one
// SK pulse per two ticks until data_in reads high, and then sends EWDS;
// write_done marks its last step. Every sequence ends with a three-step
// reset. The ready poll has no timeout. Requests while busy, ticks while
// idle and action code 3 leave the pins as they are. Register large_part at
// APB address 0 selects 8 address bits and 11-bit EWEN/EWDS (93C56/66) over
// 6 and 9 (93C46); write it only while no sequence runs. The block takes
// one item per clock cycle unless the input stalls: each item is held in
// an input register, the step logic works combinationally on it and the
// sequencer state, and the result is registered into a two-entry output
// queue, from which it leaves. The input stalls only when the queue and the
// input register together hold two items and no result leaves in that cycle.

`default_nettype none

module microwire_eeprom_master import mwe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mwe_req_if.sink     req_i,
  mwe_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       large_part;
  logic       in_accept;
  mwe_req_t   in_item;
  logic       res_valid;
  mwe_rsp_t   res_item;
  logic       pop;
  logic       q_valid;
  mwe_rsp_t   q_item;
  logic [1:0] q_count;
  logic [1:0] occupancy;

  mwe_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .large_part_o (large_part)
  );

  // Items in flight: results queued plus the one in the input register.
  // The queue has room for both, so a transfer is taken while the total
  // stays at two or less after this cycle's pop.
  assign occupancy   = q_count + {1'b0, res_valid};
  assign pop         = q_valid && rsp_o.ready;
  assign req_i.ready = (occupancy < 2'd2) || pop;
  assign in_accept   = req_i.valid && req_i.ready;

  assign in_item.action     = req_i.action;
  assign in_item.address    = req_i.address;
  assign in_item.write_data = req_i.write_data;
  assign in_item.data_in    = req_i.data_in;

  mwe_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .large_part_i (large_part),
    .in_valid_i   (in_accept),
    .in_item_i    (in_item),
    .res_valid_o  (res_valid),
    .res_o        (res_item)
  );

  mwe_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res_item),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_item),
    .count_o     (q_count)
  );

  assign rsp_o.valid        = q_valid;
  assign rsp_o.chip_select  = q_item.chip_select;
  assign rsp_o.serial_clock = q_item.serial_clock;
  assign rsp_o.serial_out   = q_item.serial_out;
  assign rsp_o.busy_res     = q_item.busy_res;
  assign rsp_o.accepted     = q_item.accepted;
  assign rsp_o.read_valid   = q_item.read_valid;
  assign rsp_o.read_data    = q_item.read_data;
  assign rsp_o.write_done   = q_item.write_done;

endmodule

`default_nettype wire

>>> hw/rtl/mwe_checker.sv
`default_nettype none

module mwe_checker import mwe_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic                chip_select,
  input logic                serial_clock,
  input logic                busy_res,
  input logic                accepted,
  input logic                read_valid,
  input logic [DataBits-1:0] read_data,
  input logic                write_done
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // A taken request always starts a sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && accepted |-> busy_res && !read_valid && !write_done)
    else $error("accepted request without busy");

  // The end of a sequence leaves the bus released and the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (read_valid || write_done) |-> !busy_res && !chip_select && !serial_clock)
    else $error("sequence ended with bus active");

  // Read data is only shown with its strobe. The term on reads and writes ending together can never fail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !read_valid |-> (read_data == '0) && !(read_valid && write_done))
    else $error("read data outside a completed read");

endmodule

bind microwire_eeprom_master mwe_checker u_mwe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .chip_select  (rsp_o.chip_select),
  .serial_clock (rsp_o.serial_clock),
  .busy_res     (rsp_o.busy_res),
  .accepted     (rsp_o.accepted),
  .read_valid   (rsp_o.read_valid),
  .read_data    (rsp_o.read_data),
  .write_done   (rsp_o.write_done)
);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the Microwire EEPROM master. A short table of
// hand-picked items comes first, then random read and write sequences run
// under both part sizes. Every item yields exactly one result, so each
// accepted item pushes one expected result into a queue. The monitor
// compares each result transfer, field by field, against the oldest entry
// in that queue.
module tb_top;
  import mwe_pkg::*;

  // Action code 3 has no meaning; the block must ignore it in every phase.
  localparam logic [1:0] ActSpare = 2'd3;

  // The part-size register sits at byte address 0.
  localparam logic [2:0] PartRegAddr = {RegLargePart, 2'b00};

  // Serial patterns as they leave the pin, first bit in the MSB. The short
  // EWEN/EWDS forms used by the 93C46 are the first nine bits of these.
  localparam logic [10:0] EnablePattern  = 11'b100_1100_0000;
  localparam logic [10:0] DisablePattern = 11'b100_0000_0000;
  localparam logic [2:0]  ReadCode       = 3'b110;
  localparam logic [2:0]  WriteCode      = 3'b101;

  // Results that can be typed in by hand for the opening rows.
  localparam mwe_rsp_t IdleRsp = '0;
  localparam mwe_rsp_t TakenRsp = '{chip_select: 1'b0, serial_clock: 1'b0, serial_out: 1'b0,
                                    busy_res: 1'b1, accepted: 1'b1, read_valid: 1'b0,
                                    read_data: '0, write_done: 1'b0};
  localparam mwe_rsp_t BusyRsp = '{chip_select: 1'b0, serial_clock: 1'b0, serial_out: 1'b0,
                                   busy_res: 1'b1, accepted: 1'b0, read_valid: 1'b0,
                                   read_data: '0, write_done: 1'b0};
  localparam mwe_rsp_t SelectRsp = '{chip_select: 1'b1, serial_clock: 1'b1, serial_out: 1'b0,
                                     busy_res: 1'b1, accepted: 1'b0, read_valid: 1'b0,
                                     read_data: '0, write_done: 1'b0};

  // Phases of the sequencer copy kept by the bench.
  typedef enum logic [4:0] {
    SqIdle, SqEnPre, SqEnBits, SqEnRst, SqCmdPre, SqCmdBits, SqAddr, SqRdData, SqRdRst,
    SqWrData, SqWrDrop, SqWrPoll, SqWrRst, SqDsPre, SqDsBits, SqDsRst
  } seq_phase_e;

  // One row of the opening table. Rows with typed set carry their result;
  // the others take it from the sequencer copy.
  typedef struct {
    logic [1:0]  action;
    logic [7:0]  address;
    logic [15:0] wdata;
    logic        din;
    bit          typed;
    mwe_rsp_t    want;
  } dir_row_t;

  localparam int NumDir = 22;

  // After reset the part is a 93C46. The table checks a tick and action code
  // 3 while idle, a write request with every address and data bit high (the
  // two top address bits must be dropped), requests and code 3 while busy,
  // and then walks the first six bits of the EWEN pattern with data_in toggling.
  dir_row_t dir_rows [NumDir] = '{
    '{ActTick,  8'h00, 16'h0000, 1'b1, 1'b1, IdleRsp},
    '{ActSpare, 8'hFF, 16'hFFFF, 1'b1, 1'b1, IdleRsp},
    '{ActWrite, 8'hFF, 16'hFFFF, 1'b0, 1'b1, TakenRsp},
    '{ActRead,  8'h00, 16'h0000, 1'b0, 1'b1, BusyRsp},
    '{ActSpare, 8'h00, 16'h0000, 1'b1, 1'b1, BusyRsp},
    '{ActWrite, 8'h00, 16'h0000, 1'b0, 1'b1, BusyRsp},
    '{ActTick,  8'h00, 16'h0000, 1'b0, 1'b1, SelectRsp},
    '{ActTick,  8'h00, 16'h0000, 1'b1, 1'b0, IdleRsp},
    '{ActTick,  8'hFF, 16'hFFFF, 1'b0, 1'b0, IdleRsp},
    '{ActTick,  8'h00, 16'h0000, 1'b1, 1'b0, IdleRsp},
    '{ActTick,  8'hFF, 16'hFFFF, 1'b0, 1'b0, IdleRsp},
    '{ActTick,  8'h00, 16'h0000, 1'b1, 1'b0, IdleRsp},
    '{ActTick,  8'hFF, 16'hFFFF, 1'b0, 1'b0, IdleRsp},
    '{ActTick,  8'h00, 16'h0000, 1'b1, 1'b0, IdleRsp},
    '{ActTick,  8'hFF, 16'hFFFF, 1'b0, 1'b0, IdleRsp},
    '{ActRead,  8'hFF, 16'hFFFF, 1'b1, 1'b0, IdleRsp},
    '{ActTick,  8'h00, 16'h0000, 1'b1, 1'b0, IdleRsp},
    '{ActTick,  8'hFF, 16'hFFFF, 1'b0, 1'b0, IdleRsp},
    '{ActSpare, 8'h00, 16'h0000, 1'b0, 1'b0, IdleRsp},
    '{ActTick,  8'h00, 16'h0000, 1'b1, 1'b0, IdleRsp},
    '{ActTick,  8'hFF, 16'hFFFF, 1'b0, 1'b0, IdleRsp},
    '{ActTick,  8'h00, 16'h0000, 1'b1, 1'b0, IdleRsp}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mwe_req_if req_if ();
  mwe_rsp_if rsp_if ();

  microwire_eeprom_master dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Copy of the sequencer state, starting from its reset values.
  logic        part_large = 1'b0;
  seq_phase_e  seq_phase  = SqIdle;
  logic [4:0]  slot       = '0;
  logic [15:0] word_sr    = '0;
  logic [7:0]  addr_hold  = '0;
  logic        job_write  = 1'b0;
  logic        pin_cs     = 1'b0;
  logic        pin_sk     = 1'b0;
  logic        pin_do     = 1'b0;

  // Results still to come, oldest first.
  mwe_rsp_t pin_results_due [$];

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned reads_finished = 0;
  int unsigned writes_finished = 0;
  int unsigned items_sent = 0;

  // While set, neither side inserts gaps, so the block runs at full rate.
  bit calm = 1'b0;

  task automatic log_mismatch(input string what, input int unsigned got,
                              input int unsigned want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic void set_pins(input logic cs, input logic sk, input logic d);
    pin_cs = cs;
    pin_sk = sk;
    pin_do = d;
  endfunction

  // One half of a bit slot: a low step when SK is high, else a high step
  // that moves on to the next bit. Returns 0 after a low step, 1 after a
  // high step with bits left and 2 after the high step of the last bit.
  function automatic int half_step(input logic b, input int unsigned len);
    if (pin_sk) begin
      set_pins(1'b1, 1'b0, b);
      return 0;
    end
    set_pins(1'b1, 1'b1, b);
    slot = slot + 5'd1;
    return (slot >= len) ? 2 : 1;
  endfunction

  // The three-step deselect with one SK pulse in the middle; true on the
  // last step.
  function automatic bit reset_half();
    set_pins(1'b0, slot == 5'd1, 1'b0);
    if (slot >= 5'd2) begin
      slot = '0;
      return 1'b1;
    end
    slot = slot + 5'd1;
    return 1'b0;
  endfunction

  // Apply one item to the sequencer copy and return the result it causes.
  task automatic sequencer_step(input mwe_req_t it, output mwe_rsp_t res);
    int unsigned cmd_len;
    int unsigned abits;
    int          r;
    logic        b;
    logic [10:0] pat;
    logic [2:0]  code;
    logic        rv;
    logic        wd;
    rv = 1'b0;
    wd = 1'b0;
    res = '0;
    cmd_len = part_large ? 11 : 9;
    abits = part_large ? 8 : 6;
    if (seq_phase == SqIdle) begin
      // A request only loads the sequence; the pins move on the next tick.
      if (it.action == ActRead || it.action == ActWrite) begin
        res.accepted = 1'b1;
        addr_hold = it.address;
        job_write = (it.action == ActWrite);
        word_sr = job_write ? it.write_data : '0;
        slot = '0;
        seq_phase = job_write ? SqEnPre : SqCmdPre;
      end
    end else if (it.action == ActTick) begin
      case (seq_phase)
        SqEnPre, SqCmdPre, SqDsPre: begin
          set_pins(1'b1, 1'b1, 1'b0);
          slot = '0;
          seq_phase = (seq_phase == SqEnPre) ? SqEnBits :
                      (seq_phase == SqCmdPre) ? SqCmdBits : SqDsBits;
        end
        SqEnBits, SqDsBits: begin
          pat = (seq_phase == SqEnBits) ? EnablePattern : DisablePattern;
          b = (slot < cmd_len) ? pat[10 - int'(slot)] : 1'b0;
          if (half_step(b, cmd_len) == 2) begin
            seq_phase = (seq_phase == SqEnBits) ? SqEnRst : SqDsRst;
            slot = '0;
          end
        end
        SqEnRst: begin
          if (reset_half()) seq_phase = SqCmdPre;
        end
        SqCmdBits: begin
          code = job_write ? WriteCode : ReadCode;
          b = (slot < 3) ? code[2 - int'(slot)] : 1'b0;
          if (half_step(b, 3) == 2) begin
            seq_phase = SqAddr;
            slot = '0;
          end
        end
        SqAddr: begin
          // Address goes out MSB first; bits above the part's width are dropped.
          b = (slot < abits) ? addr_hold[abits - 1 - int'(slot)] : 1'b0;
          if (half_step(b, abits) == 2) begin
            slot = '0;
            if (job_write) begin
              seq_phase = SqWrData;
            end else begin
              seq_phase = SqRdData;
              word_sr = '0;
            end
          end
        end
        SqRdData: begin
          // data_in is taken on every step that pulls SK low; the first of
          // the seventeen samples is the dummy bit and falls off the top.
          r = half_step(1'b0, DataBits + 1);
          if (r == 0) begin
            word_sr = {word_sr[14:0], it.data_in};
          end else if (r == 2) begin
            seq_phase = SqRdRst;
            slot = '0;
          end
        end
        SqRdRst: begin
          if (reset_half()) begin
            seq_phase = SqIdle;
            rv = 1'b1;
          end
        end
        SqWrData: begin
          b = word_sr[15];
          r = half_step(b, DataBits);
          if (r != 0) word_sr = word_sr << 1;
          if (r == 2) begin
            seq_phase = SqWrDrop;
            slot = '0;
          end
        end
        SqWrDrop: begin
          set_pins(1'b0, 1'b0, 1'b0);
          slot = '0;
          seq_phase = SqWrPoll;
        end
        SqWrPoll: begin
          // Polls come in pairs; only the SK-high step looks at data_in.
          if (!slot[0]) begin
            set_pins(1'b1, 1'b0, 1'b0);
            slot = 5'd1;
          end else begin
            set_pins(1'b1, 1'b1, 1'b0);
            slot = '0;
            if (it.data_in) seq_phase = SqWrRst;
          end
        end
        SqWrRst: begin
          if (reset_half()) seq_phase = SqDsPre;
        end
        SqDsRst: begin
          if (reset_half()) begin
            seq_phase = SqIdle;
            wd = 1'b1;
          end
        end
        default: begin
          seq_phase = SqIdle;
        end
      endcase
    end
    res.chip_select = pin_cs;
    res.serial_clock = pin_sk;
    res.serial_out = pin_do;
    res.busy_res = (seq_phase != SqIdle);
    res.read_valid = rv;
    res.read_data = rv ? word_sr : '0;
    res.write_done = wd;
  endtask

  // Most gaps are zero, a quarter are short and a few are long.
  function automatic int pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Drive one item at a falling edge and hold it until its transfer. The
  // expectation is recorded at the edge that takes the item.
  task automatic push_item(input mwe_req_t it, input bit typed, input mwe_rsp_t want);
    mwe_rsp_t predicted;
    int       gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.action <= it.action;
    req_if.address <= it.address;
    req_if.write_data <= it.write_data;
    req_if.data_in <= it.data_in;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sequencer_step(it, predicted);
    pin_results_due.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Lower valid and wait until every result has come back, plus a margin
  // for the path through the block.
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pin_results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the part size over APB once the block is idle, then read it back.
  task automatic set_part_size(input logic big_part);
    drain_results();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PartRegAddr;
    pwdata <= 32'(big_part);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    part_large = big_part;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== 32'(big_part)) log_mismatch("large_part readback", prdata, big_part);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: mostly complete read and write sequences with random
  // address, data and data_in, salted with requests while busy, code 3 and
  // ticks while idle. The ready poll sees data_in high one time in four so
  // that it runs for a few pairs. Stops once the quota of live items is met
  // and the sequence in flight has ended.
  task automatic run_sequences(input int unsigned quota);
    int unsigned live;
    int unsigned roll;
    mwe_req_t    it;
    live = 0;
    while (live < quota || seq_phase != SqIdle) begin
      it.address = 8'($urandom);
      it.write_data = 16'($urandom);
      it.data_in = 1'($urandom);
      roll = $urandom_range(0, 19);
      if (seq_phase == SqIdle) begin
        calm = ($urandom_range(0, 3) == 0);
        if (roll == 0) begin
          it.action = ActTick;
        end else if (roll == 1) begin
          it.action = ActSpare;
        end else begin
          it.action = roll[0] ? ActRead : ActWrite;
          live++;
        end
      end else begin
        if (roll == 0) begin
          it.action = $urandom_range(0, 1) ? ActRead : ActWrite;
        end else if (roll == 1) begin
          it.action = ActSpare;
        end else begin
          it.action = ActTick;
          live++;
        end
        if (seq_phase == SqWrPoll) it.data_in = ($urandom_range(0, 3) == 0);
      end
      push_item(it, 1'b0, IdleRsp);
    end
  endtask

  // Result side: ready drops for random stretches, long ones now and then.
  initial begin : sink_pacing
    int hold;
    rsp_if.ready = 1'b0;
    forever begin
      hold = pick_gap();
      repeat (hold) begin
        @(negedge clk_i);
        rsp_if.ready <= 1'b0;
      end
      hold = $urandom_range(1, 8);
      repeat (hold) begin
        @(negedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    mwe_rsp_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pin_results_due.size() == 0) begin
        log_mismatch("result with nothing expected", 0, 0);
      end else begin
        want = pin_results_due.pop_front();
        if (rsp_if.chip_select !== want.chip_select)
          log_mismatch("chip_select", rsp_if.chip_select, want.chip_select);
        if (rsp_if.serial_clock !== want.serial_clock)
          log_mismatch("serial_clock", rsp_if.serial_clock, want.serial_clock);
        if (rsp_if.serial_out !== want.serial_out)
          log_mismatch("serial_out", rsp_if.serial_out, want.serial_out);
        if (rsp_if.busy_res !== want.busy_res)
          log_mismatch("busy_res", rsp_if.busy_res, want.busy_res);
        if (rsp_if.accepted !== want.accepted)
          log_mismatch("accepted", rsp_if.accepted, want.accepted);
        if (rsp_if.read_valid !== want.read_valid)
          log_mismatch("read_valid", rsp_if.read_valid, want.read_valid);
        if (rsp_if.read_data !== want.read_data)
          log_mismatch("read_data", rsp_if.read_data, want.read_data);
        if (rsp_if.write_done !== want.write_done)
          log_mismatch("write_done", rsp_if.write_done, want.write_done);
        results_checked++;
        if (want.read_valid) reads_finished++;
        if (want.write_done) writes_finished++;
      end
    end
  end

  initial begin : stimulus
    mwe_req_t it;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ActTick;
    req_if.address = '0;
    req_if.write_data = '0;
    req_if.data_in = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Opening table, run as a 93C46 straight out of reset.
    for (int i = 0; i < NumDir; i++) begin
      it.action = dir_rows[i].action;
      it.address = dir_rows[i].address;
      it.write_data = dir_rows[i].wdata;
      it.data_in = dir_rows[i].din;
      push_item(it, dir_rows[i].typed, dir_rows[i].want);
    end

    // Finish the write the table started, then more traffic on the small
    // part, then the large part, then back to the small one.
    run_sequences(50);
    set_part_size(1'b1);
    run_sequences(90);
    set_part_size(1'b0);
    run_sequences(90);

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d items and checked %0d results on both part sizes.",
             items_sent, results_checked);
    $display("Sequences finished: %0d reads, %0d writes; %0d mismatches.",
             reads_finished, writes_finished, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Far above the slowest legal run: the opening table and the three random runs,
  // each item behind the longest gap and the longest result stall.
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results still expected.", pin_results_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
